### hdl/owp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owp_pkg
// Shared types, constants and tables for the ordered weighted pooling core.
// ----------------------------------------------------------------------------
package owp_pkg;

  // Number of input maps; the port list carries exactly this many samples.
  localparam int NUM_INPUTS    = 4;
  localparam int SRC_W         = 2;
  localparam int SAMPLE_W      = 16;
  localparam int WEIGHT_W      = 16;
  localparam int PROD_W        = SAMPLE_W + WEIGHT_W;
  localparam int SUM_W         = 34;
  localparam int POS_IN_W      = 8;
  localparam int POS_AW        = 12;
  localparam int POSITIONS_DEF = 256;
  localparam int POS_IN_DEPTH  = 1 << POS_IN_W;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [SRC_W-1:0]           src_t;

  // 0.2 * (rank + 1) rounded to the nearest Q4.12 step
  localparam weight_t W_RESET [NUM_INPUTS] = '{
    16'sd819, 16'sd1638, 16'sd2458, 16'sd3277
  };

  // Control handed from the top level to every lane
  typedef struct packed {
    logic              adv;      // pipeline advances this cycle
    logic              load;     // load item transferred this cycle
    src_t              rank;     // rank slot of the load
    logic              clr;      // clearing pass writes the reset weight
    logic [POS_AW-1:0] addr;     // table row
    logic              clamp;    // negative weights count as zero
  } lane_ctl_t;

  // Position-to-row map: position modulo the table depth, built by counting.
  typedef logic [POS_AW-1:0] pos_tbl_t [POS_IN_DEPTH];

  function automatic pos_tbl_t pos_mod_tbl(input int unsigned n);
    pos_tbl_t    t;
    int unsigned m;
    m = 0;
    for (int i = 0; i < POS_IN_DEPTH; i++) begin
      t[i] = POS_AW'(m);
      if (m + 1 >= n) begin
        m = 0;
      end else begin
        m = m + 1;
      end
    end
    return t;
  endfunction

endpackage
`default_nettype wire

### hdl/owp_rank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owp_rank
// Ranks the input samples in descending order (ties: higher index first) and
// registers the ranked values and their source indexes.
// ----------------------------------------------------------------------------
module owp_rank (
  input  wire logic             clk,
  input  wire logic             adv,
  input  wire owp_pkg::sample_t x_in   [owp_pkg::NUM_INPUTS],
  output owp_pkg::sample_t      val_r  [owp_pkg::NUM_INPUTS],
  output owp_pkg::src_t         src_r  [owp_pkg::NUM_INPUTS]
);

  owp_pkg::src_t    rank_c [owp_pkg::NUM_INPUTS];
  owp_pkg::src_t    src_nxt [owp_pkg::NUM_INPUTS];
  owp_pkg::sample_t val_nxt [owp_pkg::NUM_INPUTS];

  // rank of each sample = number of samples placed ahead of it
  always_comb begin
    for (int i = 0; i < owp_pkg::NUM_INPUTS; i++) begin
      rank_c[i] = '0;
      for (int j = 0; j < owp_pkg::NUM_INPUTS; j++) begin
        if (j != i && (x_in[j] > x_in[i] || (x_in[j] == x_in[i] && j > i))) begin
          rank_c[i] = rank_c[i] + owp_pkg::SRC_W'(1);
        end
      end
    end
  end

  // ranks form a permutation, so each slot is hit exactly once
  always_comb begin
    for (int r = 0; r < owp_pkg::NUM_INPUTS; r++) begin
      src_nxt[r] = '0;
      val_nxt[r] = '0;
      for (int i = 0; i < owp_pkg::NUM_INPUTS; i++) begin
        if (rank_c[i] == owp_pkg::SRC_W'(r)) begin
          src_nxt[r] = owp_pkg::SRC_W'(i);
          val_nxt[r] = x_in[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_r <= val_nxt;
      src_r <= src_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/owp_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owp_lane
// One rank lane: weight memory for its rank, clamp and multiplier.
// ----------------------------------------------------------------------------
module owp_lane #(
  parameter int LANE      = 0,
  parameter int POSITIONS = owp_pkg::POSITIONS_DEF,
  parameter int PW        = 8
) (
  input  wire logic              clk,
  input  wire owp_pkg::lane_ctl_t ctl,
  input  wire owp_pkg::weight_t  wdata,
  input  wire owp_pkg::sample_t  val,
  output owp_pkg::prod_t         prod_r
);

  owp_pkg::weight_t mem [POSITIONS];
  owp_pkg::weight_t rd_r;
  owp_pkg::weight_t w_eff;
  logic             we;
  owp_pkg::weight_t wr_val;

  assign we     = ctl.clr || (ctl.load && ctl.rank == owp_pkg::SRC_W'(LANE));
  assign wr_val = ctl.clr ? owp_pkg::W_RESET[LANE] : wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[ctl.addr[PW-1:0]] <= wr_val;
    end
    if (ctl.adv) begin
      rd_r <= mem[ctl.addr[PW-1:0]];
    end
  end

  assign w_eff = (ctl.clamp && rd_r[owp_pkg::WEIGHT_W-1]) ? '0 : rd_r;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      prod_r <= owp_pkg::PROD_W'(w_eff * val);
    end
  end

endmodule
`default_nettype wire

### hdl/owp_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owp_merge
// Adds the lane products and registers the result with the source indexes.
// ----------------------------------------------------------------------------
module owp_merge (
  input  wire logic            clk,
  input  wire logic            adv,
  input  wire owp_pkg::prod_t  prod  [owp_pkg::NUM_INPUTS],
  input  wire owp_pkg::src_t   src   [owp_pkg::NUM_INPUTS],
  output owp_pkg::sum_t        sum_r,
  output owp_pkg::src_t        src_r [owp_pkg::NUM_INPUTS]
);

  owp_pkg::src_t s2_src_r [owp_pkg::NUM_INPUTS];
  owp_pkg::sum_t sum_nxt;

  // four products of at most 2^30 each: the sum always fits, no saturation
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < owp_pkg::NUM_INPUTS; i++) begin
      sum_nxt = sum_nxt + owp_pkg::SUM_W'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_src_r <= src;
      src_r    <= s2_src_r;
      sum_r    <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/ordered_weighted_pooling_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_weighted_pooling_core
// Ordered weighted averaging over four input maps with a per-position,
// per-rank weight table.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_stall | req_type, position, weight_rank,
//          |                     | weight_value, x0..x3
//  out     | out_valid/out_stall | weighted_sum, source_of_rank0..3
//  cfg     | cfg_valid/cfg_ready | clamp_negative
//
//  One item per cycle while in_stall is low. A compute item passes the stages
//  ranking + table read, lane multiply, merge add. Load items give no result.
//  After reset a clearing pass writes the reset weights to every table row,
//  with in_stall high; cfg writes are taken at all times.
//  A result held by out_stall freezes the whole pipeline and raises in_stall in
//  the same cycle; with no result waiting the pipeline moves and bubbles close.
// ----------------------------------------------------------------------------
module ordered_weighted_pooling_core #(
  parameter int POSITIONS = owp_pkg::POSITIONS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,

  input  wire logic            in_valid,
  output      logic            in_stall,
  input  wire logic            in_req_type,
  input  wire logic [7:0]      in_position,
  input  wire logic [1:0]      in_weight_rank,
  input  wire logic signed [15:0] in_weight_value,
  input  wire logic signed [15:0] in_x0,
  input  wire logic signed [15:0] in_x1,
  input  wire logic signed [15:0] in_x2,
  input  wire logic signed [15:0] in_x3,

  output      logic            out_valid,
  input  wire logic            out_stall,
  output      logic signed [33:0] out_weighted_sum,
  output      logic [1:0]      out_source_of_rank0,
  output      logic [1:0]      out_source_of_rank1,
  output      logic [1:0]      out_source_of_rank2,
  output      logic [1:0]      out_source_of_rank3,

  input  wire logic            cfg_valid,
  output      logic            cfg_ready,
  input  wire logic            cfg_clamp_negative
);

  localparam int PW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam owp_pkg::pos_tbl_t POS_TBL = owp_pkg::pos_mod_tbl(POSITIONS);

  logic              clamp_r;
  logic              clearing_r;
  logic [PW-1:0]     clr_idx_r;
  logic              s1_vld_r;
  logic              s2_vld_r;
  logic              out_vld_r;
  logic              adv;
  logic              xfer;
  owp_pkg::lane_ctl_t ctl;

  owp_pkg::sample_t  x_in   [owp_pkg::NUM_INPUTS];
  owp_pkg::sample_t  s1_val [owp_pkg::NUM_INPUTS];
  owp_pkg::src_t     s1_src [owp_pkg::NUM_INPUTS];
  owp_pkg::prod_t    prod   [owp_pkg::NUM_INPUTS];
  owp_pkg::src_t     o_src  [owp_pkg::NUM_INPUTS];
  owp_pkg::sum_t     o_sum;

  assign adv       = !out_vld_r || !out_stall;
  assign in_stall  = !adv || clearing_r;
  assign xfer      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      clamp_r <= cfg_clamp_negative;
    end
  end

  // clearing pass: one table row per cycle in every lane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      if (clr_idx_r == PW'(POSITIONS - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= xfer && in_req_type == owp_pkg::REQ_COMPUTE;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  always_comb begin
    ctl.adv   = adv;
    ctl.load  = xfer && in_req_type == owp_pkg::REQ_LOAD;
    ctl.rank  = in_weight_rank;
    ctl.clr   = clearing_r;
    ctl.addr  = clearing_r ? owp_pkg::POS_AW'(clr_idx_r) : POS_TBL[in_position];
    ctl.clamp = clamp_r;
  end

  assign x_in[0] = in_x0;
  assign x_in[1] = in_x1;
  assign x_in[2] = in_x2;
  assign x_in[3] = in_x3;

  owp_rank u_rank (
    .clk   (clk),
    .adv   (adv),
    .x_in  (x_in),
    .val_r (s1_val),
    .src_r (s1_src)
  );

  for (genvar g = 0; g < owp_pkg::NUM_INPUTS; g++) begin : g_lane
    owp_lane #(
      .LANE      (g),
      .POSITIONS (POSITIONS),
      .PW        (PW)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .wdata  (in_weight_value),
      .val    (s1_val[g]),
      .prod_r (prod[g])
    );
  end

  owp_merge u_merge (
    .clk   (clk),
    .adv   (adv),
    .prod  (prod),
    .src   (s1_src),
    .sum_r (o_sum),
    .src_r (o_src)
  );

  assign out_valid           = out_vld_r;
  assign out_weighted_sum    = o_sum;
  assign out_source_of_rank0 = o_src[0];
  assign out_source_of_rank1 = o_src[1];
  assign out_source_of_rank2 = o_src[2];
  assign out_source_of_rank3 = o_src[3];

`ifndef SYNTHESIS
  a_no_xfer_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> in_stall)
    else $error("input transfer during clearing pass");

  a_clear_after_reset : assert property (@(posedge clk)
    !rst_n |=> clearing_r)
    else $error("clearing pass not started by reset");

  a_sources_permutation : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (((4'b1 << out_source_of_rank0) | (4'b1 << out_source_of_rank1) |
                    (4'b1 << out_source_of_rank2) | (4'b1 << out_source_of_rank3))
                   == 4'hF))
    else $error("rank sources are not a permutation");

  a_sum_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_weighted_sum <= $signed(34'h1_0000_0000) &&
                   out_weighted_sum >= $signed(34'h3_0000_0000)))
    else $error("weighted sum out of range");

  a_result_from_compute : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s2_vld_r))
    else $error("result without a compute item");
`endif

endmodule
`default_nettype wire

### verif/tb_ordered_weighted_pooling_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_weighted_pooling_core
// Self-checking bench for the ordered weighted pooling core. Streams weight
// loads and compute requests through the input channel, and keeps a local
// weight table and clamp setting to predict each compute result. Every output
// transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ordered_weighted_pooling_core;

  localparam int POS_N      = owp_pkg::POSITIONS_DEF;
  localparam int SETTLE     = 8;      // pipeline is three stages deep
  localparam int WDOG_LIMIT = 2000;
  localparam int HOLD_LEN   = 200;
  localparam int MAX_GAP    = 14;
  localparam int PHASE_LEN  = 200;
  localparam int PHASES     = 6;

  typedef struct packed {
    logic                                       req;
    logic [owp_pkg::POS_IN_W-1:0]               pos;
    owp_pkg::src_t                              rank;
    owp_pkg::weight_t                           wval;
    owp_pkg::sample_t [owp_pkg::NUM_INPUTS-1:0] x;
  } owp_req_t;

  typedef struct packed {
    owp_pkg::sum_t                           sum;
    owp_pkg::src_t [owp_pkg::NUM_INPUTS-1:0] src;
  } owp_res_t;

  logic               clk                 = 1'b0;
  logic               rst_n               = 1'b0;
  logic               in_valid            = 1'b0;
  logic               in_stall;
  logic               in_req_type         = owp_pkg::REQ_LOAD;
  logic [7:0]         in_position         = '0;
  logic [1:0]         in_weight_rank      = '0;
  logic signed [15:0] in_weight_value     = '0;
  logic signed [15:0] in_x0               = '0;
  logic signed [15:0] in_x1               = '0;
  logic signed [15:0] in_x2               = '0;
  logic signed [15:0] in_x3               = '0;
  logic               out_valid;
  logic               out_stall           = 1'b0;
  logic signed [33:0] out_weighted_sum;
  logic [1:0]         out_source_of_rank0;
  logic [1:0]         out_source_of_rank1;
  logic [1:0]         out_source_of_rank2;
  logic [1:0]         out_source_of_rank3;
  logic               cfg_valid           = 1'b0;
  logic               cfg_ready;
  logic               cfg_clamp_negative  = 1'b0;

  // local copy of the block state
  owp_pkg::weight_t weight_mem [owp_pkg::NUM_INPUTS][POS_N];
  logic             clamp_model = 1'b0;

  owp_req_t pending_reqs[$];
  owp_res_t expected_results[$];
  owp_req_t cur_req;

  logic tx_idle   = 1'b0;
  logic rx_idle   = 1'b0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   tx_wait   = 0;
  int   rx_wait   = 0;

  int err_count     = 0;
  int results_seen  = 0;
  int loads_seen    = 0;
  int computes_seen = 0;
  int cfg_writes    = 0;
  int quiet_cycles  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ordered_weighted_pooling_core #(
    .POSITIONS (POS_N)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_position         (in_position),
    .in_weight_rank      (in_weight_rank),
    .in_weight_value     (in_weight_value),
    .in_x0               (in_x0),
    .in_x1               (in_x1),
    .in_x2               (in_x2),
    .in_x3               (in_x3),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_weighted_sum    (out_weighted_sum),
    .out_source_of_rank0 (out_source_of_rank0),
    .out_source_of_rank1 (out_source_of_rank1),
    .out_source_of_rank2 (out_source_of_rank2),
    .out_source_of_rank3 (out_source_of_rank3),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_clamp_negative  (cfg_clamp_negative)
  );

  // Rank the four samples (descending, ties go to the higher input index) and
  // sum rank weight times ranked sample. Four 2^30 products cannot leave 34 bits.
  function automatic owp_res_t owa_predict(owp_req_t rq);
    owp_res_t         res;
    int               xv [owp_pkg::NUM_INPUTS];
    int               order [owp_pkg::NUM_INPUTS];
    int               slot;
    int               p;
    longint           acc;
    owp_pkg::weight_t w;
    p   = int'(rq.pos) % POS_N;
    acc = 0;
    for (int i = 0; i < owp_pkg::NUM_INPUTS; i++) begin
      xv[i] = $signed(rq.x[i]);
    end
    for (int i = 0; i < owp_pkg::NUM_INPUTS; i++) begin
      slot = 0;
      for (int j = 0; j < owp_pkg::NUM_INPUTS; j++) begin
        if (j != i && (xv[j] > xv[i] || (xv[j] == xv[i] && j > i))) begin
          slot++;
        end
      end
      order[slot] = i;
    end
    for (int r = 0; r < owp_pkg::NUM_INPUTS; r++) begin
      w = weight_mem[r][p];
      if (clamp_model && w < 0) begin
        w = '0;
      end
      acc += longint'(w) * longint'(xv[order[r]]);
      res.src[r] = owp_pkg::src_t'(order[r]);
    end
    res.sum = owp_pkg::sum_t'(acc);
    return res;
  endfunction

  function automatic void add_req(owp_req_t rq);
    pending_reqs.insert(pending_reqs.size(), rq);
  endfunction

  function automatic void record_request(owp_req_t rq);
    if (rq.req == owp_pkg::REQ_LOAD) begin
      if (int'(rq.rank) < owp_pkg::NUM_INPUTS) begin
        weight_mem[rq.rank][int'(rq.pos) % POS_N] = rq.wval;
      end
      loads_seen++;
    end else begin
      expected_results.insert(expected_results.size(), owa_predict(rq));
      computes_seen++;
    end
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(0, 2)) - 16'd1;  // ties around zero
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic owp_req_t rand_request();
    owp_req_t rq;
    rq.req  = ($urandom_range(0, 9) < 3) ? owp_pkg::REQ_LOAD : owp_pkg::REQ_COMPUTE;
    // half the traffic hits a few positions so loaded weights get used
    rq.pos  = ($urandom_range(0, 1) == 1) ? owp_pkg::POS_IN_W'($urandom_range(0, 7))
                                          : owp_pkg::POS_IN_W'($urandom);
    rq.rank = owp_pkg::src_t'($urandom);
    rq.wval = rand_value();
    for (int i = 0; i < owp_pkg::NUM_INPUTS; i++) begin
      rq.x[i] = rand_value();
    end
    return rq;
  endfunction

  function automatic owp_req_t mk_load(int p, int rk, int w);
    owp_req_t rq;
    rq      = rand_request();
    rq.req  = owp_pkg::REQ_LOAD;
    rq.pos  = owp_pkg::POS_IN_W'(p);
    rq.rank = owp_pkg::src_t'(rk);
    rq.wval = 16'(w);
    return rq;
  endfunction

  function automatic owp_req_t mk_compute(int p, int a, int b, int c, int d);
    owp_req_t rq;
    rq      = rand_request();
    rq.req  = owp_pkg::REQ_COMPUTE;
    rq.pos  = owp_pkg::POS_IN_W'(p);
    rq.x[0] = 16'(a);
    rq.x[1] = 16'(b);
    rq.x[2] = 16'(c);
    rq.x[3] = 16'(d);
    return rq;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    $display("[%0t] MISMATCH %s: got %0d, want %0d (result %0d)",
             $time, what, got, want, results_seen);
  endtask

  // Input driver: one transfer per accepted request, random gap per request when tx_idle is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        record_request(cur_req);
      end
      if (!(in_valid && in_stall)) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req         = pending_reqs.pop_front();
          in_req_type     <= cur_req.req;
          in_position     <= cur_req.pos;
          in_weight_rank  <= cur_req.rank;
          in_weight_value <= cur_req.wval;
          in_x0           <= cur_req.x[0];
          in_x1           <= cur_req.x[1];
          in_x2           <= cur_req.x[2];
          in_x3           <= cur_req.x[3];
          in_valid        <= 1'b1;
          tx_wait         = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off, counted on its own
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor and output stall generator
  always @(posedge clk) begin : check_results
    owp_res_t      want;
    owp_pkg::src_t got_src [owp_pkg::NUM_INPUTS];
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending, weighted_sum", out_weighted_sum, 0);
      end else begin
        want       = expected_results.pop_front();
        got_src[0] = out_source_of_rank0;
        got_src[1] = out_source_of_rank1;
        got_src[2] = out_source_of_rank2;
        got_src[3] = out_source_of_rank3;
        if (out_weighted_sum !== want.sum) begin
          report_mismatch("weighted_sum", out_weighted_sum, $signed(want.sum));
        end
        for (int r = 0; r < owp_pkg::NUM_INPUTS; r++) begin
          if (got_src[r] !== want.src[r]) begin
            report_mismatch($sformatf("source_of_rank%0d", r), got_src[r], want.src[r]);
          end
        end
      end
      rx_wait = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= (rx_wait > 0) || (hold_left > 0);
  end

  // Watchdog: cycles without any transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("tb_ordered_weighted_pooling_core: done, errors");
      $finish;
    end
  end

  // Called at a rising edge
  task automatic write_clamp(input logic val);
    cfg_valid          <= 1'b1;
    cfg_clamp_negative <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid   <= 1'b0;
    clamp_model = val;
    cfg_writes++;
  endtask

  // Loads give no result, so let the pipeline empty after the last one
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : run_phases
    for (int r = 0; r < owp_pkg::NUM_INPUTS; r++) begin
      for (int p = 0; p < POS_N; p++) begin
        weight_mem[r][p] = owp_pkg::weight_t'((8192 * (r + 1) + 5) / 10);
      end
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default weights, ties, extremes, then loaded extreme weights
    write_clamp(1'b0);
    @(negedge clk);
    add_req(mk_compute(0, 0, 0, 0, 0));
    add_req(mk_compute(255, 32767, 32767, 32767, 32767));
    add_req(mk_compute(17, -32768, -32768, -32768, -32768));
    add_req(mk_compute(42, 32767, -32768, 0, -1));
    add_req(mk_compute(3, 1, 2, 3, 4));
    add_req(mk_compute(3, 4, 3, 2, 1));
    add_req(mk_compute(9, 5, 5, -5, -5));
    add_req(mk_load(255, 0, 32767));
    add_req(mk_load(255, 1, -32768));
    add_req(mk_load(255, 2, -1));
    add_req(mk_load(255, 3, 0));
    add_req(mk_compute(255, 32767, -32768, 100, -100));
    add_req(mk_compute(255, -32768, -32768, -32768, -32768));
    for (int r = 0; r < owp_pkg::NUM_INPUTS; r++) begin
      add_req(mk_load(0, r, -32768));
    end
    add_req(mk_compute(0, -32768, -32768, -32768, -32768));
    add_req(mk_compute(0, 32767, 32767, 32767, 32767));
    // load followed directly by a compute that uses it
    add_req(mk_load(100, 2, 4096));
    add_req(mk_compute(100, 7, -7, 300, 0));
    wait_drained();

    // clamp on: negative weights at positions 0 and 255 count as zero
    write_clamp(1'b1);
    @(negedge clk);
    rx_idle = 1'b1;
    add_req(mk_compute(255, 32767, -32768, 100, -100));
    add_req(mk_compute(0, -32768, -32768, -32768, -32768));
    add_req(mk_compute(0, 32767, 32767, 32767, 32767));
    wait_drained();

    for (int k = 0; k < PHASES; k++) begin
      write_clamp(k[0]);
      @(negedge clk);
      tx_idle = k[0];
      rx_idle = (k == 2 || k == 3 || k == 5);
      // one phase with a long output hold-off while requests keep coming
      if (k == 4) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_LEN; n++) begin
        add_req(rand_request());
      end
      wait_drained();
    end

    $display("Checked %0d results from %0d compute and %0d load transfers.",
             results_seen, computes_seen, loads_seen);
    $display("Clamp written %0d times with both settings; idle, stall and hold-off mixes used.",
             cfg_writes);
    if (err_count == 0) begin
      $display("tb_ordered_weighted_pooling_core: done, clean");
    end else begin
      $display("tb_ordered_weighted_pooling_core: done, errors");
    end
    $finish;
  end

endmodule
